>>> src/olpfr_pkg.sv
// ----------------------------------------------------------------------------
// olpfr_pkg
// Shared types, constants and the sequencer microcode table for the OLED
// page frame store and bus byte sequencer.
// ----------------------------------------------------------------------------
package olpfr_pkg;

    localparam int DEF_PANEL_WIDTH  = 128;
    localparam int DEF_PANEL_HEIGHT = 64;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0] BUS_ADDR_RESET = 8'h78;
    localparam logic [7:0] CTRL_CMD_BYTE  = 8'h00;
    localparam logic [7:0] CTRL_DATA_BYTE = 8'h40;
    localparam logic [7:0] PAGE_CMD_BASE  = 8'hB0;
    localparam logic [7:0] COL_HI_BASE    = 8'h10;
    localparam logic [7:0] COL_LO_MASK    = 8'h0F;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_ADDR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET = 1'b1;

    typedef enum logic [1:0] {
        CMD_DRAW    = 2'd0,
        CMD_REFRESH = 2'd1,
        CMD_COMMAND = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    // sequencer step counter (transfer phase)
    typedef enum logic [3:0] {
        STEP_IDLE   = 4'd0,
        STEP_C_ADDR = 4'd1,
        STEP_C_CTRL = 4'd2,
        STEP_C_CMD  = 4'd3,
        STEP_R_ADDR = 4'd4,
        STEP_R_CTRL = 4'd5,
        STEP_R_PAGE = 4'd6,
        STEP_R_HI   = 4'd7,
        STEP_R_LO   = 4'd8,
        STEP_D_ADDR = 4'd9,
        STEP_D_CTRL = 4'd10,
        STEP_D_DATA = 4'd11
    } step_t;

    typedef enum logic [2:0] {
        SRC_ADDR      = 3'd0,
        SRC_CTRL_CMD  = 3'd1,
        SRC_COMMAND   = 3'd2,
        SRC_PAGE      = 3'd3,
        SRC_COL_HI    = 3'd4,
        SRC_COL_LO    = 3'd5,
        SRC_CTRL_DATA = 3'd6,
        SRC_MEM       = 3'd7
    } src_t;

    typedef struct packed {
        logic  emit;
        src_t  src;
        logic  start;
        logic  stop;
        logic  col_clr;
        logic  last_jump;   // stay on this step until the last column
        step_t next_step;
    } ucode_t;

    typedef enum logic [1:0] {
        CTL_CLEAR   = 2'd0,
        CTL_IDLE    = 2'd1,
        CTL_DRAW_WR = 2'd2,
        CTL_EMIT    = 2'd3
    } ctl_state_t;

    typedef struct packed {
        logic load_refresh;
        logic load_command;
        logic advance;
    } seq_req_t;

    typedef struct packed {
        logic       busy;
        logic       emit;
        logic [7:0] bus_byte;
        logic       start_before;
        logic       stop_after;
    } seq_out_t;

    function automatic ucode_t uc_word(input src_t src, input logic start,
                                       input logic stop, input logic col_clr,
                                       input logic last_jump, input step_t nxt);
        ucode_t w;
        w.emit      = 1'b1;
        w.src       = src;
        w.start     = start;
        w.stop      = stop;
        w.col_clr   = col_clr;
        w.last_jump = last_jump;
        w.next_step = nxt;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        w = '0;
        w.next_step = STEP_IDLE;
        case (s)
            STEP_C_ADDR: w = uc_word(SRC_ADDR,      1'b1, 1'b0, 1'b0, 1'b0, STEP_C_CTRL);
            STEP_C_CTRL: w = uc_word(SRC_CTRL_CMD,  1'b0, 1'b0, 1'b0, 1'b0, STEP_C_CMD);
            STEP_C_CMD:  w = uc_word(SRC_COMMAND,   1'b0, 1'b1, 1'b0, 1'b0, STEP_IDLE);
            STEP_R_ADDR: w = uc_word(SRC_ADDR,      1'b1, 1'b0, 1'b0, 1'b0, STEP_R_CTRL);
            STEP_R_CTRL: w = uc_word(SRC_CTRL_CMD,  1'b0, 1'b0, 1'b0, 1'b0, STEP_R_PAGE);
            STEP_R_PAGE: w = uc_word(SRC_PAGE,      1'b0, 1'b0, 1'b0, 1'b0, STEP_R_HI);
            STEP_R_HI:   w = uc_word(SRC_COL_HI,    1'b0, 1'b0, 1'b0, 1'b0, STEP_R_LO);
            STEP_R_LO:   w = uc_word(SRC_COL_LO,    1'b0, 1'b1, 1'b0, 1'b0, STEP_D_ADDR);
            STEP_D_ADDR: w = uc_word(SRC_ADDR,      1'b1, 1'b0, 1'b0, 1'b0, STEP_D_CTRL);
            STEP_D_CTRL: w = uc_word(SRC_CTRL_DATA, 1'b0, 1'b0, 1'b1, 1'b0, STEP_D_DATA);
            STEP_D_DATA: w = uc_word(SRC_MEM,       1'b0, 1'b0, 1'b0, 1'b1, STEP_D_DATA);
            default: begin
                w = '0;
                w.next_step = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> src/olpfr_ram.sv
// ----------------------------------------------------------------------------
// olpfr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module olpfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/olpfr_seq.sv
// ----------------------------------------------------------------------------
// olpfr_seq
// Microcoded bus byte sequencer: step counter, microcode table lookup,
// column counter, pending transfer registers and the byte source mux.
// ----------------------------------------------------------------------------
module olpfr_seq import olpfr_pkg::*; #(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  seq_req_t             req,
    input  logic [3:0]           page_number,
    input  logic [7:0]           command_value,
    input  logic [7:0]           mem_rdata,
    output logic [$clog2(PANEL_WIDTH*PANEL_HEIGHT/8)-1:0] rd_addr,
    output seq_out_t             seq_o
);

    localparam int DEPTH      = PANEL_WIDTH * PANEL_HEIGHT / 8;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int SUM_W      = ADDR_W + 9;
    localparam int PAGE_COUNT = PANEL_HEIGHT / 8;
    localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int COL_W      = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;

    step_t             step_reg, step_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [7:0]        command_reg, command_next;
    logic [7:0]        bus_addr_reg, bus_addr_next;
    logic [6:0]        col_off_reg, col_off_next;

    ucode_t uc;
    logic   last_col;

    assign uc       = ucode_rom(step_reg);
    assign last_col = (col_reg == COL_W'(PANEL_WIDTH - 1));

    always_comb begin
        step_next    = step_reg;
        col_next     = col_reg;
        page_next    = page_reg;
        command_next = command_reg;
        if (req.load_refresh) begin
            step_next = STEP_R_ADDR;
            page_next = PAGE_W'(page_number);
        end else if (req.load_command) begin
            step_next    = STEP_C_ADDR;
            command_next = command_value;
        end else if (req.advance) begin
            if (uc.last_jump && last_col) begin
                step_next = STEP_IDLE;
                col_next  = '0;
            end else begin
                step_next = uc.next_step;
                if (uc.col_clr) begin
                    col_next = '0;
                end else if (uc.last_jump) begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    always_comb begin
        bus_addr_next = bus_addr_reg;
        col_off_next  = col_off_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BUS_ADDR:   bus_addr_next = cfg_wdata;
                CFG_COL_OFFSET: col_off_next  = cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= STEP_IDLE;
            col_reg      <= '0;
            page_reg     <= '0;
            command_reg  <= '0;
            bus_addr_reg <= BUS_ADDR_RESET;
            col_off_reg  <= '0;
        end else begin
            step_reg     <= step_next;
            col_reg      <= col_next;
            page_reg     <= page_next;
            command_reg  <= command_next;
            bus_addr_reg <= bus_addr_next;
            col_off_reg  <= col_off_next;
        end
    end

    assign rd_addr = ADDR_W'(SUM_W'(page_reg) * SUM_W'(PANEL_WIDTH) + SUM_W'(col_reg));

    always_comb begin
        seq_o.busy         = (step_reg != STEP_IDLE);
        seq_o.emit         = uc.emit;
        seq_o.start_before = uc.start;
        seq_o.stop_after   = uc.stop | (uc.last_jump & last_col);
        case (uc.src)
            SRC_ADDR:      seq_o.bus_byte = bus_addr_reg;
            SRC_CTRL_CMD:  seq_o.bus_byte = CTRL_CMD_BYTE;
            SRC_COMMAND:   seq_o.bus_byte = command_reg;
            SRC_PAGE:      seq_o.bus_byte = PAGE_CMD_BASE + 8'(3'(page_reg));
            SRC_COL_HI:    seq_o.bus_byte = COL_HI_BASE | 8'(col_off_reg[6:4]);
            SRC_COL_LO:    seq_o.bus_byte = 8'(col_off_reg) & COL_LO_MASK;
            SRC_CTRL_DATA: seq_o.bus_byte = CTRL_DATA_BYTE;
            SRC_MEM:       seq_o.bus_byte = mem_rdata;
            default:       seq_o.bus_byte = '0;
        endcase
    end

endmodule

>>> src/oled_page_framebuffer_refresh.sv
// ----------------------------------------------------------------------------
// oled_page_framebuffer_refresh
// Page-mode frame store for a monochrome OLED panel with a microcoded
// sequencer that hands out bus bytes, one per tick request while a byte is due.
//
//  channel | ports                  | carries
//  --------+------------------------+-----------------------------------------
//  input   | s_tvalid/tready/tdata  | draw, refresh, command or tick request
//  result  | m_tvalid/tready/tdata  | bus byte with start/stop marks, or reject
//  config  | cfg_wr_en/index/wdata  | bus address byte, column offset
//
// Draw reads the frame RAM, then writes the byte back; a draw off the panel,
// refresh/command loads, dropped refreshes and idle ticks keep s_tready high.
// A tick that sends a byte reads the frame RAM and then loads the output
// register; a busy reject loads it too. The load waits while a result is held.
// After reset a clearing pass zeroes all PANEL_WIDTH*PANEL_HEIGHT/8 words of
// the frame RAM (1024 by default) with s_tready low; config writes go in then.
// ----------------------------------------------------------------------------
module oled_page_framebuffer_refresh import olpfr_pkg::*; #(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [8:0] pixel_x, [16:9] pixel_y, [17] pixel_on, [21:18] page_number,
    // [29:22] command_value, [31:30] zero
    input  logic [31:0]          s_tdata,
    // [1:0] cmd
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] bus_byte
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    // [0] start_before, [1] rejected
    output logic [1:0]           m_tuser,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_wdata
);

    localparam int DEPTH      = PANEL_WIDTH * PANEL_HEIGHT / 8;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int SUM_W      = ADDR_W + 9;
    localparam int PAGE_COUNT = PANEL_HEIGHT / 8;

    cmd_t             cmd;
    logic [8:0]       pixel_x;
    logic [7:0]       pixel_y;
    logic             pixel_on;
    logic [3:0]       page_number;
    logic [7:0]       command_value;

    assign cmd           = cmd_t'(s_tuser[1:0]);
    assign pixel_x       = s_tdata[8:0];
    assign pixel_y       = s_tdata[16:9];
    assign pixel_on      = s_tdata[17];
    assign page_number   = s_tdata[21:18];
    assign command_value = s_tdata[29:22];

    ctl_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0] draw_addr_reg;
    logic [2:0]        draw_bit_reg;
    logic              draw_on_reg;
    logic              rej_reg;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_byte_reg;
    logic              m_start_reg, m_stop_reg, m_rej_reg;

    logic              accept, out_free, out_load;
    logic              pixel_ok, page_ok;
    logic [ADDR_W-1:0] draw_addr;
    logic [7:0]        draw_mask;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr, seq_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    seq_req_t seq_req;
    seq_out_t seq_o;

    assign s_tready = (state_reg == CTL_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign pixel_ok = !pixel_x[8] && (10'(pixel_x[7:0]) < 10'(PANEL_WIDTH))
                   && !pixel_y[7] && (8'(pixel_y[6:0]) < 8'(PANEL_HEIGHT));
    assign page_ok  = (5'(page_number) < 5'(PAGE_COUNT));
    assign draw_addr = ADDR_W'(SUM_W'(pixel_y[5:3]) * SUM_W'(PANEL_WIDTH)
                             + SUM_W'(pixel_x[7:0]));
    assign draw_mask = 8'd1 << draw_bit_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CTL_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = CTL_IDLE;
                end
            end
            CTL_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_DRAW: begin
                            if (pixel_ok) state_next = CTL_DRAW_WR;
                        end
                        CMD_REFRESH, CMD_COMMAND: begin
                            if (seq_o.busy) state_next = CTL_EMIT;
                        end
                        CMD_TICK: begin
                            if (seq_o.emit) state_next = CTL_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            CTL_DRAW_WR: state_next = CTL_IDLE;
            CTL_EMIT: begin
                if (out_free) state_next = CTL_IDLE;
            end
            default: state_next = CTL_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ram_we        = 1'b0;
        ram_waddr     = clr_addr_reg;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = seq_raddr;
        seq_req       = '0;
        out_load      = 1'b0;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            CTL_CLEAR: begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            CTL_IDLE: begin
                if (accept) begin
                    case (cmd)
                        CMD_DRAW: begin
                            ram_re    = pixel_ok;
                            ram_raddr = draw_addr;
                        end
                        CMD_REFRESH: seq_req.load_refresh = !seq_o.busy && page_ok;
                        CMD_COMMAND: seq_req.load_command = !seq_o.busy;
                        CMD_TICK: begin
                            ram_re          = seq_o.emit;
                            // no byte due: just settle the step counter
                            seq_req.advance = !seq_o.emit;
                        end
                        default: ;
                    endcase
                end
            end
            CTL_DRAW_WR: begin
                ram_we    = 1'b1;
                ram_waddr = draw_addr_reg;
                ram_wdata = draw_on_reg ? (ram_rdata | draw_mask)
                                        : (ram_rdata & ~draw_mask);
            end
            CTL_EMIT: begin
                out_load        = out_free;
                seq_req.advance = out_free && !rej_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= CTL_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
            rej_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
            if (accept) begin
                rej_reg <= (cmd == CMD_REFRESH) || (cmd == CMD_COMMAND);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            draw_addr_reg <= draw_addr;
            draw_bit_reg  <= pixel_y[2:0];
            draw_on_reg   <= pixel_on;
        end
        if (out_load) begin
            m_byte_reg  <= rej_reg ? 8'd0 : seq_o.bus_byte;
            m_start_reg <= !rej_reg && seq_o.start_before;
            m_stop_reg  <= !rej_reg && seq_o.stop_after;
            m_rej_reg   <= rej_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_stop_reg;
    assign m_tuser  = {m_rej_reg, m_start_reg};

    olpfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    olpfr_seq #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .req           (seq_req),
        .page_number   (page_number),
        .command_value (command_value),
        .mem_rdata     (ram_rdata),
        .rd_addr       (seq_raddr),
        .seq_o         (seq_o)
    );

endmodule

>>> src/olpfr_checker.sv
// ----------------------------------------------------------------------------
// olpfr_checker
// Port-level checks for the OLED page frame store, bound to the top level.
// ----------------------------------------------------------------------------
module olpfr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // held result must not change until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a rejected request carries no byte and no bus conditions
    a_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 8'd0 && !m_tuser[0] && !m_tlast)
        else $error("reject with non-zero payload");

    // no transfer is a single byte, so start and stop never share one
    a_start_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tlast))
        else $error("start and stop on the same byte");

    // clearing pass: nothing accepted or shown right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("activity straight after reset");

endmodule

bind oled_page_framebuffer_refresh olpfr_checker u_olpfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
